[rtl/dual_tone_generator_defines.svh]
// ----------------------------------------------------------------------------
// dual tone generator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DUAL_TONE_GENERATOR_DEFINES_SVH
`define DUAL_TONE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define DTG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define DTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dtg_pkg.sv]
// ----------------------------------------------------------------------------
// dtg_pkg
// constants, sequencer states and polynomial coefficients of the tone generator
// ----------------------------------------------------------------------------
package dtg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int OUTPUT_BITS     = 12;

    // register file
    localparam int STEP_W  = 32;
    localparam int AMP_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LOW_RST  = 32'd187904819;
    localparam logic [STEP_W-1:0] STEP_HIGH_RST = 32'd236223201;
    localparam logic [AMP_W-1:0]  AMP_RST       = 16'd6554;

    // sine polynomial datapath
    localparam int ADDR_W = TABLE_ADDR_BITS + 2;
    localparam int X_W    = 30;
    localparam int X_PAD  = X_W - 1 - TABLE_ADDR_BITS;
    localparam int P_W    = 31;
    localparam int V_W    = 17;
    localparam int S_W    = 18;

    // shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 31;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [P_W-1:0] P_INIT      = 31'd3864;
    localparam logic [2:0]     HORNER_LAST = 3'd4;

    localparam logic [MUL_B_W-1:0] FULL_CODE = MUL_B_W'((1 << OUTPUT_BITS) - 1);
    localparam logic [34:0]        HALF_BIAS = 35'd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_HORNER,
        ST_ODD,
        ST_ROUND,
        ST_GAIN,
        ST_SCALE
    } t_state;

    // horner coefficients of the odd taylor series in q30, highest order first
    function automatic logic [P_W-1:0] horner_coef(input logic [2:0] idx);
        logic [P_W-1:0] c;
        case (idx)
            3'd0:    c = 31'd172272;
            3'd1:    c = 31'd5026995;
            3'd2:    c = 31'd85569306;
            3'd3:    c = 31'd693598668;
            3'd4:    c = 31'd1686629713;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/dual_tone_generator.sv]
// ----------------------------------------------------------------------------
// dual_tone_generator
// two-tone direct digital synthesis producing unsigned dac codes
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall with i_tick. a transaction with i_tick = 1
// emits the sample of the current phases and then advances both phases by
// their steps; i_tick = 0 emits the same sample and leaves the phases alone.
// output channel: o_valid / i_stall with o_sample, held in an output register.
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index and
// i_cfg_data; index 0 and 1 are the phase steps, 2 the amplitude, 3 ignored.
// both sines are evaluated by one shared 33x31 multiplier stepping through a
// polynomial sequence per tone (square, horner steps, odd term, rounding),
// then a gain step and a full-scale scaling and saturation step.
// o_valid rises when the scaling step loads the output register.
// o_stall is high while a sample is being computed.
// if the previous sample still waits under i_stall, the finished sample
// holds in the scaling step until the output register frees up.
// reset (synchronous, active low) clears phases, restores default steps
// and amplitude, and empties the output register.
module dual_tone_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_tick,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dtg_pkg::OUTPUT_BITS-1:0] o_sample,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dtg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dtg_pkg::*;

    t_state r_state, n_state;

    logic [STEP_W-1:0]     r_step_low, r_step_high;
    logic [AMP_W-1:0]      r_amp;
    logic [PHASE_BITS-1:0] r_phase_first, n_phase_first;
    logic [PHASE_BITS-1:0] r_phase_second, n_phase_second;
    logic [ADDR_W-1:0]     r_addr_first, n_addr_first;
    logic [ADDR_W-1:0]     r_addr_second, n_addr_second;
    logic                  r_tone, n_tone;
    logic [2:0]            r_hcnt, n_hcnt;
    logic [X_W-1:0]        r_x2, n_x2;
    logic [P_W-1:0]        r_p, n_p;
    logic signed [S_W-1:0] r_s, n_s;
    logic [MUL_A_W-1:0]    r_t, n_t;
    logic                  r_tneg, n_tneg;
    logic                  r_out_valid, n_out_valid;
    logic [OUTPUT_BITS-1:0] r_sample, n_sample;

    logic                    in_accept;
    logic                    can_load;
    logic [ADDR_W-1:0]       cur_addr;
    logic [1:0]              quad;
    logic [TABLE_ADDR_BITS-1:0] k_idx;
    logic [X_W-1:0]          x_val;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       prod;
    logic [31:0]             p_round;
    logic [V_W-1:0]          v_val;
    logic [S_W-1:0]          s_abs;
    logic [34:0]             t_full;
    logic [31:0]             q_val;
    logic [63:0]             step_low_wide, step_high_wide;

    assign in_accept = i_valid && !o_stall;
    assign can_load  = !r_out_valid || !i_stall;

    assign step_low_wide  = {32'b0, r_step_low};
    assign step_high_wide = {32'b0, r_step_high};

    // table address of the tone in work, mirrored in odd quadrants
    assign cur_addr = r_tone ? r_addr_second : r_addr_first;
    assign quad     = cur_addr[ADDR_W-1 -: 2];
    assign k_idx    = quad[0] ? ~cur_addr[TABLE_ADDR_BITS-1:0]
                              : cur_addr[TABLE_ADDR_BITS-1:0];
    assign x_val    = {k_idx, 1'b1, {X_PAD{1'b0}}};

    assign prod    = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
    assign p_round = {1'b0, r_p} + 32'd16384;
    assign v_val   = p_round[31:15];
    assign s_abs   = r_s[S_W-1] ? S_W'(-r_s) : S_W'(r_s);
    assign q_val   = prod[63:32];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_accept) n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_HORNER;
            ST_HORNER: if (r_hcnt == HORNER_LAST) n_state = ST_ODD;
            ST_ODD:    n_state = ST_ROUND;
            ST_ROUND:  n_state = r_tone ? ST_GAIN : ST_SQUARE;
            ST_GAIN:   n_state = ST_SCALE;
            ST_SCALE:  if (can_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and multiplier operand selection
    always_comb begin
        n_phase_first  = r_phase_first;
        n_phase_second = r_phase_second;
        n_addr_first   = r_addr_first;
        n_addr_second  = r_addr_second;
        n_tone         = r_tone;
        n_hcnt         = r_hcnt;
        n_x2           = r_x2;
        n_p            = r_p;
        n_s            = r_s;
        n_t            = r_t;
        n_tneg         = r_tneg;
        n_sample       = r_sample;
        n_out_valid    = r_out_valid && i_stall;
        mul_a          = '0;
        mul_b          = '0;
        t_full         = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_addr_first  = r_phase_first[PHASE_BITS-1 -: ADDR_W];
                    n_addr_second = r_phase_second[PHASE_BITS-1 -: ADDR_W];
                    n_tone        = 1'b0;
                    n_s           = '0;
                    if (i_tick) begin
                        n_phase_first  = r_phase_first + step_low_wide[PHASE_BITS-1:0];
                        n_phase_second = r_phase_second + step_high_wide[PHASE_BITS-1:0];
                    end
                end
            end
            ST_SQUARE: begin
                mul_a  = MUL_A_W'(x_val);
                mul_b  = MUL_B_W'(x_val);
                n_x2   = prod[59:30];
                n_p    = P_INIT;
                n_hcnt = '0;
            end
            ST_HORNER: begin
                mul_a  = MUL_A_W'(r_x2);
                mul_b  = r_p;
                n_p    = horner_coef(r_hcnt) - prod[60:30];
                n_hcnt = r_hcnt + 3'd1;
            end
            ST_ODD: begin
                mul_a = MUL_A_W'(x_val);
                mul_b = r_p;
                n_p   = prod[60:30];
            end
            ST_ROUND: begin
                // negative half of the turn subtracts
                if (quad[1]) n_s = r_s - $signed({1'b0, v_val});
                else         n_s = r_s + $signed({1'b0, v_val});
                n_tone = 1'b1;
            end
            ST_GAIN: begin
                mul_a = MUL_A_W'(s_abs);
                mul_b = MUL_B_W'(r_amp);
                if (r_s[S_W-1]) t_full = HALF_BIAS - {2'b0, prod[32:0]};
                else            t_full = HALF_BIAS + {2'b0, prod[32:0]};
                n_tneg = t_full[34];
                n_t    = t_full[MUL_A_W-1:0];
            end
            ST_SCALE: begin
                mul_a = r_t;
                mul_b = FULL_CODE;
                if (can_load) begin
                    n_out_valid = 1'b1;
                    if (r_tneg)                          n_sample = '0;
                    else if (q_val > 32'(FULL_CODE))     n_sample = OUTPUT_BITS'(FULL_CODE);
                    else                                 n_sample = q_val[OUTPUT_BITS-1:0];
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_phase_first  <= '0;
            r_phase_second <= '0;
            r_out_valid    <= 1'b0;
            r_tone         <= 1'b0;
            r_hcnt         <= '0;
        end else begin
            r_state        <= n_state;
            r_phase_first  <= n_phase_first;
            r_phase_second <= n_phase_second;
            r_out_valid    <= n_out_valid;
            r_tone         <= n_tone;
            r_hcnt         <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_first  <= n_addr_first;
        r_addr_second <= n_addr_second;
        r_x2          <= n_x2;
        r_p           <= n_p;
        r_s           <= n_s;
        r_t           <= n_t;
        r_tneg        <= n_tneg;
        r_sample      <= n_sample;
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_low  <= STEP_LOW_RST;
            r_step_high <= STEP_HIGH_RST;
            r_amp       <= AMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STEP_LOW:  r_step_low  <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_HIGH: r_step_high <= i_cfg_data[STEP_W-1:0];
                CFG_AMPLITUDE: r_amp       <= i_cfg_data[AMP_W-1:0];
                default: begin
                    r_amp <= r_amp;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/dtg_checker.sv]
// ----------------------------------------------------------------------------
// dtg_checker
// port-level temporal checks of the tone generator
// ----------------------------------------------------------------------------
`include "dual_tone_generator_defines.svh"

module dtg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [dtg_pkg::OUTPUT_BITS-1:0] o_sample
);

    // a stalled result stays offered
    `DTG_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sample), "stalled result dropped or changed")

    // an accepted transaction keeps the block busy
    `DTG_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "block not busy after accepting an item")

    // a new result only appears out of a busy computation
    `DTG_ASSERT_SAME(a_result_from_work, $rose(o_valid), $past(o_stall), "result appeared without work")

    // the block only returns to idle with its result in the output register
    `DTG_ASSERT_SAME(a_idle_has_result, $fell(o_stall), o_valid, "idle reached without a result")

endmodule

bind dual_tone_generator dtg_checker u_dtg_checker (.*);

[bench/dual_tone_generator_tb.sv]
// ----------------------------------------------------------------------------
// dual_tone_generator_tb
// drives tick transactions and register writes into the tone generator and
// checks every dac code against a typed code or a local model of the two phase accumulators,
// the quarter-wave sine table and the gain and saturation stage
// ----------------------------------------------------------------------------
module dual_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtg_pkg::*;

    localparam int ROM_DEPTH  = 1 << TABLE_ADDR_BITS;
    localparam int CELL_SHIFT = 30 - TABLE_ADDR_BITS - 1;
    localparam int QUAD_SHIFT = PHASE_BITS - TABLE_ADDR_BITS - 2;
    localparam longint DAC_MAX = (longint'(1) << OUTPUT_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROUNDS = 9;
    localparam int ROUND_LEN = 50;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [OUTPUT_BITS-1:0] CODE_TOP    = '1;
    localparam logic [OUTPUT_BITS-1:0] CODE_BOTTOM = '0;
    localparam logic [OUTPUT_BITS-1:0] CODE_MID    = OUTPUT_BITS'((1 << (OUTPUT_BITS - 1)) - 1);

    // taylor coefficients in q30, highest order term first
    localparam longint unsigned HORNER_Q30 [5] = '{
        172272, 5026995, 85569306, 693598668, 1686629713
    };
    localparam longint unsigned HORNER_SEED = 3864;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic                     tick;
        logic                     known;
        logic [OUTPUT_BITS-1:0]   code;
    } t_row;

    localparam int DIR_LEN = 25;
    localparam t_row DIR_PLAN [DIR_LEN] = '{
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_LOW,  32'h4000_0000, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_HIGH, 32'h4000_0000, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_AMPLITUDE, 32'h0000_FFFF, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        // both tones at a quarter turn with full gain clip high
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b0, 1'b1, CODE_TOP},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b1, CODE_TOP},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        // three quarter turn, clips low
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b1, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_HIGH, 32'hC000_0000, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_AMPLITUDE, 32'h0,         1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b1, CODE_MID},
        // unused index must not touch the gain
        '{ROW_CFG,  CFG_SPARE,     32'hFFFF_FFFF, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b1, CODE_MID},
        '{ROW_CFG,  CFG_STEP_LOW,  32'hFFFF_FFFF, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_HIGH, 32'h0,         1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_AMPLITUDE, {16'h0, AMP_RST}, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_LOW,  STEP_LOW_RST,  1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_CFG,  CFG_STEP_HIGH, STEP_HIGH_RST, 1'b0, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM},
        '{ROW_ITEM, CFG_STEP_LOW,  32'h0,         1'b1, 1'b0, CODE_BOTTOM}
    };

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic                       i_tick      = 1'b0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [OUTPUT_BITS-1:0]     o_sample;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    // local copy of the generator state
    int unsigned                sine_quarter [ROM_DEPTH];
    logic [PHASE_BITS-1:0]      tone_a_phase;
    logic [PHASE_BITS-1:0]      tone_b_phase;
    logic [STEP_W-1:0]          tone_a_step;
    logic [STEP_W-1:0]          tone_b_step;
    logic [AMP_W-1:0]           gain;

    logic [OUTPUT_BITS-1:0]     dac_codes_due [$];
    int                         fail_count  = 0;
    int                         idle_cycles = 0;
    bit                         steady      = 1'b0;

    dual_tone_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_tick      (i_tick),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // table cell k holds the sine at the cell midpoint, in q1.15
    function automatic int unsigned quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        x   = 64'(2 * k + 1) << CELL_SHIFT;
        x2  = (x * x) >> 30;
        acc = HORNER_SEED;
        for (int i = 0; i < 5; i++) begin
            acc = HORNER_Q30[i] - ((x2 * acc) >> 30);
        end
        acc = (x * acc) >> 30;
        return int'((acc + (64'd1 << 14)) >> 15);
    endfunction

    function automatic int tone_level(input logic [PHASE_BITS-1:0] phase);
        logic [ADDR_W-1:0]          slot;
        logic [1:0]                 quadrant;
        logic [TABLE_ADDR_BITS-1:0] entry;
        int                         level;
        slot     = ADDR_W'(phase >> QUAD_SHIFT);
        quadrant = slot[ADDR_W-1 -: 2];
        entry    = slot[TABLE_ADDR_BITS-1:0];
        if (quadrant[0]) begin
            entry = ~entry;
        end
        level = int'(sine_quarter[entry]);
        return quadrant[1] ? -level : level;
    endfunction

    // dac code for the current phases, then the phase advance on a tick
    function automatic logic [OUTPUT_BITS-1:0] synth_next_code(input logic tick);
        longint mix;
        longint acc;
        longint code;
        mix = longint'(tone_level(tone_a_phase) + tone_level(tone_b_phase));
        acc = longint'(gain) * mix * DAC_MAX + DAC_MAX * (longint'(1) << 31);
        if (acc < 0) begin
            code = 0;
        end else begin
            code = acc >>> 32;
            if (code > DAC_MAX) begin
                code = DAC_MAX;
            end
        end
        if (tick) begin
            tone_a_phase = tone_a_phase + PHASE_BITS'(tone_a_step);
            tone_b_phase = tone_b_phase + PHASE_BITS'(tone_b_step);
        end
        return OUTPUT_BITS'(code);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        logic [STEP_W-1:0] s;
        case ($urandom_range(0, 6))
            0:       s = '0;
            1:       s = '1;
            2:       s = 32'h4000_0000;
            3:       s = STEP_LOW_RST;
            4:       s = STEP_W'($urandom_range(1, 1 << 20));
            default: s = $urandom();
        endcase
        return s;
    endfunction

    task automatic issue_tick(input logic tick, input logic known,
                              input logic [OUTPUT_BITS-1:0] typed_code);
        logic [OUTPUT_BITS-1:0] code;
        i_cfg_valid <= 1'b0;
        i_valid     <= 1'b1;
        i_tick      <= tick;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        code = synth_next_code(tick);
        dac_codes_due.push_back(known ? typed_code : code);
    endtask

    // hold off until every outstanding dac code has been seen
    task automatic drain_samples();
        i_valid <= 1'b0;
        while (dac_codes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_samples();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_STEP_LOW:  tone_a_step = data[STEP_W-1:0];
            CFG_STEP_HIGH: tone_b_step = data[STEP_W-1:0];
            CFG_AMPLITUDE: gain        = data[AMP_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_row row;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            sine_quarter[k] = quarter_sine(k);
        end
        tone_a_phase = '0;
        tone_b_phase = '0;
        tone_a_step  = STEP_LOW_RST;
        tone_b_step  = STEP_HIGH_RST;
        gain         = AMP_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_LEN; r++) begin
            row = DIR_PLAN[r];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.data);
            end else begin
                issue_tick(row.tick, row.known, row.code);
                maybe_idle();
            end
        end

        // first round keeps the reset steps and gain
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            if (rnd > 0) begin
                write_reg(CFG_STEP_LOW, pick_step());
                write_reg(CFG_STEP_HIGH, pick_step());
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_AMPLITUDE, 32'h0000_FFFF);
                    1:       write_reg(CFG_AMPLITUDE, {16'h0, AMP_RST});
                    default: write_reg(CFG_AMPLITUDE, $urandom());
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(CFG_SPARE, $urandom());
                end
            end
            steady = (rnd == 3);
            for (int n = 0; n < ROUND_LEN; n++) begin
                issue_tick($urandom_range(0, 99) < 80, 1'b0, CODE_BOTTOM);
                if (n == ROUND_LEN / 2) begin
                    drain_samples();
                end else begin
                    maybe_idle();
                end
            end
            steady = 1'b0;
        end

        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < 14);
    end

    always @(posedge i_clk) begin
        logic [OUTPUT_BITS-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dac_codes_due.size() == 0) begin
                $display("%0t: unexpected sample transaction, actual %0d",
                         $time, o_sample);
                fail_count++;
            end else begin
                want = dac_codes_due.pop_front();
                if (o_sample !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, o_sample);
                    fail_count++;
                end
            end
        end
    end

    // no transaction of any kind for too long means the block is hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d samples outstanding",
                         $time, dac_codes_due.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
